/* design/pwl_pkg.sv */
// Shared types and constants for the piecewise-linear position lookup.
package pwl_pkg;

    localparam int BREAKPOINTS = 16;
    localparam int IDX_W       = $clog2(BREAKPOINTS);
    localparam int N_W         = $clog2(BREAKPOINTS + 1);
    localparam int DIV_STEPS   = 33;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic REG_POINTS_IDX = 1'b0;
    localparam logic MODE_WRITE     = 1'b0;
    localparam logic MODE_QUERY     = 1'b1;

    typedef enum logic [2:0] {
        KIND_BEFORE = 3'd0,
        KIND_EXACT  = 3'd1,
        KIND_FLAT   = 3'd2,
        KIND_INTERP = 3'd3,
        KIND_AFTER  = 3'd4,
        KIND_EMPTY  = 3'd5
    } kind_t;

    typedef struct packed {
        logic               mode;
        logic [3:0]         point_index;
        logic signed [31:0] time_value;
        logic signed [31:0] position_value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] position_out;
        kind_t              case_kind;
        logic [3:0]         segment_index;
    } out_word_t;

    // query token travelling along the row of breakpoint cells
    typedef struct packed {
        logic               valid;
        logic               found;
        kind_t              kind;
        logic [N_W-1:0]     idx;
        logic [IDX_W-1:0]   seg;
        logic signed [31:0] t;
        logic signed [31:0] t0;
        logic signed [31:0] p0;
        logic signed [31:0] t1;
        logic signed [31:0] p1;
    } token_t;

endpackage

/* design/pwl_cell.sv */
// One breakpoint cell: holds a time and position and steps the query token on.
module pwl_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic signed [31:0] wr_time,
    input  logic signed [31:0] wr_pos,
    input  logic [pwl_pkg::N_W-1:0] n_used,
    input  pwl_pkg::token_t    tok_in,
    output pwl_pkg::token_t    tok_out
);
    import pwl_pkg::*;

    logic signed [31:0] time_reg;
    logic signed [31:0] pos_reg;
    token_t             tok_reg;
    token_t             tok_next;
    logic               active;
    logic               hit;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            time_reg <= wr_time;
            pos_reg  <= wr_pos;
        end
    end

    always_comb begin
        tok_next     = tok_in;
        tok_next.idx = tok_in.idx + 1'b1;
        active       = tok_in.valid && !tok_in.found && (tok_in.idx < n_used);
        hit          = active && (tok_in.t <= time_reg);
        if (hit) begin
            tok_next.found = 1'b1;
            tok_next.seg   = tok_in.idx[IDX_W-1:0];
            tok_next.t1    = time_reg;
            tok_next.p1    = pos_reg;
            if (tok_in.idx == '0) begin
                tok_next.kind = KIND_BEFORE;
            end else if (tok_in.t == time_reg) begin
                tok_next.kind = KIND_EXACT;
            end else if (pos_reg == tok_in.p0) begin
                tok_next.kind = KIND_FLAT;
            end else begin
                tok_next.kind = KIND_INTERP;
            end
        end else if (active) begin
            tok_next.seg = tok_in.idx[IDX_W-1:0];
            tok_next.t0  = time_reg;
            tok_next.p0  = pos_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* design/pwl_div.sv */
// Restoring divider, one quotient bit per cycle, 33-bit quotient.
module pwl_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [32:0] quotient
);
    import pwl_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [31:0]          rem_reg;
    logic [31:0]          dvs_reg;
    logic [32:0]          num_reg;
    logic [32:0]          quot_reg;
    logic [32:0]          trial;
    logic                 qbit;
    logic [32:0]          diff;

    always_comb begin
        trial = {rem_reg, num_reg[32]};
        diff  = trial - {1'b0, dvs_reg};
        qbit  = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient fits 33 bits, so the top 31 dividend bits start below the divisor
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= {1'b0, dividend[63:33]};
            num_reg  <= dividend[32:0];
            dvs_reg  <= divisor;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= qbit ? diff[31:0] : trial[31:0];
            num_reg  <= {num_reg[31:0], 1'b0};
            quot_reg <= {quot_reg[31:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

/* design/piecewise_linear_position_lookup_top.sv */
// Top level of the piecewise-linear position lookup.
// Breakpoints sit in a row of BREAKPOINTS cells; a query token walks the row one cell
// per cycle, so every query walks the whole row whatever the count in use. A write only
// loads its cell. A query that needs no interpolation goes from the scan straight to the
// output state, which raises m_valid; an interpolated one adds a 32x32 multiply, a 64-bit
// correction add and a bit-serial divide for a 33-bit quotient before that state. A query
// with no breakpoints in use skips the scan and goes straight to the output state. One item
// is in the core at a time; the output register lets the next item enter while a word
// waits, and the core holds in its output state only while an earlier word is still
// stalled there.
module piecewise_linear_position_lookup_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  pwl_pkg::in_word_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output pwl_pkg::out_word_t               m_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pwl_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pwl_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pwl_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import pwl_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_ACC  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    state_t             state_reg;
    state_t             state_next;
    logic [4:0]         points_reg;
    logic [N_W-1:0]     n_eff;
    logic               s_fire;
    logic [BREAKPOINTS-1:0] wr_en;
    token_t             tok [BREAKPOINTS+1];
    token_t             tok_end;

    kind_t              kind_reg;
    logic [IDX_W-1:0]   seg_reg;
    logic signed [31:0] pos_reg;
    logic signed [31:0] p0_reg;
    logic               neg_reg;
    logic [32:0]        mag_reg;
    logic [31:0]        dz_reg;
    logic [31:0]        span_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        prod_full;
    logic signed [31:0] last_reg;
    logic               m_valid_reg;
    out_word_t          m_data_reg;

    logic signed [32:0] dp;
    logic signed [32:0] dz_w;
    logic signed [32:0] span_w;
    logic signed [33:0] sum;
    logic signed [31:0] res;
    logic               div_done;
    logic [32:0]        div_q;
    logic               out_free;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_reg <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_POINTS_IDX) begin
            points_reg <= pwdata[4:0];
        end
    end
    assign prdata = (paddr[2] == REG_POINTS_IDX) ? APB_DATA_W'(points_reg) : '0;
    assign pready = 1'b1;

    assign n_eff   = (32'(points_reg) > BREAKPOINTS) ? N_W'(BREAKPOINTS) : N_W'(points_reg);
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // cell row
    always_comb begin
        tok[0]       = '0;
        tok[0].valid = s_fire && s_data.mode == MODE_QUERY && n_eff != '0;
        tok[0].kind  = KIND_AFTER;
        tok[0].t     = s_data.time_value;
    end

    for (genvar i = 0; i < BREAKPOINTS; i++) begin : g_cell
        assign wr_en[i] = s_fire && s_data.mode == MODE_WRITE &&
                          (32'(s_data.point_index) == i);
        pwl_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr_en   (wr_en[i]),
            .wr_time (s_data.time_value),
            .wr_pos  (s_data.position_value),
            .n_used  (n_eff),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    assign tok_end = tok[BREAKPOINTS];

    // segment operands
    always_comb begin
        dp     = 33'(tok_end.p1) - 33'(tok_end.p0);
        dz_w   = 33'(tok_end.t) - 33'(tok_end.t0);
        span_w = 33'(tok_end.t1) - 33'(tok_end.t0);
    end

    assign prod_full = prod_reg + (mag_reg[32] ? {dz_reg, 32'b0} : 64'b0);

    pwl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_ACC),
        .dividend (prod_full),
        .divisor  (span_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign sum      = 34'(p0_reg) + (neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q}));
    assign out_free = !m_valid_reg || m_ready;
    assign res      = (kind_reg == KIND_EMPTY) ? last_reg :
                      (pos_reg == 32'sh80000000) ? 32'sh7fffffff : -pos_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_data.mode == MODE_QUERY) begin
                    state_next = (n_eff == '0) ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tok_end.valid) begin
                    state_next = (tok_end.found && tok_end.kind == KIND_INTERP) ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            last_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
                last_reg    <= res;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                kind_reg <= KIND_EMPTY;
                seg_reg  <= '0;
            end
            ST_SCAN: begin
                kind_reg <= tok_end.kind;
                seg_reg  <= tok_end.seg;
                pos_reg  <= (tok_end.kind == KIND_AFTER) ? tok_end.p0 : tok_end.p1;
                p0_reg   <= tok_end.p0;
                neg_reg  <= dp[32];
                mag_reg  <= dp[32] ? 33'(-dp) : 33'(dp);
                dz_reg   <= dz_w[31:0];
                span_reg <= span_w[31:0];
            end
            ST_MUL: begin
                prod_reg <= 64'(mag_reg[31:0]) * 64'(dz_reg);
            end
            ST_DIV: begin
                if (div_done) begin
                    pos_reg <= sat34(sum);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_data_reg.position_out  <= res;
                    m_data_reg.case_kind     <= kind_reg;
                    m_data_reg.segment_index <= 4'(seg_reg);
                end
            end
            default: begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* design/pwl_checker.sv */
// Port-level checks for the position lookup, bound to the top level.
module pwl_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input pwl_pkg::in_word_t              s_data,
    input logic                           m_valid,
    input logic                           m_ready,
    input pwl_pkg::out_word_t             m_data
);
    import pwl_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word dropped or changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result or busy state survived reset");

    a_seg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.case_kind == KIND_EMPTY || m_data.case_kind == KIND_BEFORE)
        |-> m_data.segment_index == 4'd0)
        else $error("segment index not zero for empty table or before first");

    a_write_no_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.mode == MODE_WRITE && !m_valid |=> !m_valid)
        else $error("breakpoint write produced a result word");

endmodule

bind piecewise_linear_position_lookup_top pwl_checker u_pwl_checker (.*);
